[rtl/core/ccb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the contrast crop bounds core.
// ----------------------------------------------------------------------------
package ccb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int SCAN_W = (X_W > Y_W) ? X_W : Y_W;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 11;
  localparam int SUM_W  = 18;
  localparam int TOT_W  = 28;
  localparam int CF_W   = 17;
  localparam int MF_W   = 16;
  localparam int GOAL_W = TOT_W + CF_W;
  localparam int CM_W   = DIM_W + MF_W + 1;
  localparam int FRAC_SH = 16;
  localparam int IDX_W  = 2;

  localparam logic [CM_W-1:0] HALF_Q16 = CM_W'(32768);

  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_CONTRAST_FR  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_MAX_CROP_FR  = 2'd3;

  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(1024);
  localparam logic [CF_W-1:0]  RST_CFRAC  = CF_W'(3277);
  localparam logic [MF_W-1:0]  RST_MFRAC  = MF_W'(16384);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_GOAL,
    ST_FRONT,
    ST_BACK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic pix;
    logic clr;
    logic goal;
    logic scan;
    logic back_init;
    logic back_fin;
    logic axis;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic img_end;
    logic scan_done;
  } status_t;

endpackage

[rtl/core/ccb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_ctrl
// Sequencer: pixel update, per-axis bound scans, result strobe and the
// column store clearing sweep.
// ----------------------------------------------------------------------------
module ccb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ccb_pkg::status_t  status,
  output logic              busy,
  output logic              out_valid,
  output ccb_pkg::cmd_t     cmd
);
  import ccb_pkg::*;

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      ST_CLEAR: if (status.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_PIX;
      ST_PIX: begin
        if (status.img_end) begin
          state_nxt = ST_GOAL;
          axis_nxt  = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GOAL:  state_nxt = ST_FRONT;
      ST_FRONT: if (status.scan_done) state_nxt = ST_BACK;
      ST_BACK: begin
        if (status.scan_done) begin
          if (axis_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_GOAL;
            axis_nxt  = 1'b1;
          end
        end
      end
      ST_DONE:  state_nxt = ST_CLEAR;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.axis  = axis_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.take = start;
      end
      ST_PIX:   cmd.pix = 1'b1;
      ST_GOAL:  cmd.goal = 1'b1;
      ST_FRONT: begin
        cmd.scan      = ~status.scan_done;
        cmd.back_init = status.scan_done;
      end
      ST_BACK: begin
        cmd.scan     = ~status.scan_done;
        cmd.back_fin = status.scan_done;
      end
      ST_DONE: begin
        cmd.fin   = 1'b1;
        out_valid = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  a_take_to_pix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_PIX)
    else $error("accepted pixel not followed by update");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && state_r == ST_CLEAR)
    else $error("result strobe not single or sweep skipped");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.pix, cmd.clr, cmd.goal, cmd.back_init, cmd.back_fin, cmd.fin}))
    else $error("conflicting datapath commands");

endmodule

[rtl/core/ccb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_datapath
// Configuration registers, line stores, contrast accumulators and the
// sequential bound scan unit.
// ----------------------------------------------------------------------------
module ccb_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccb_pkg::cmd_t               cmd,
  output ccb_pkg::status_t            status,
  input  logic [ccb_pkg::PIX_W-1:0]   in_pixel,
  input  logic                        cfg_we,
  input  logic [ccb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ccb_pkg::CF_W-1:0]    cfg_data,
  output logic [ccb_pkg::DIM_W-1:0]   out_col_first,
  output logic [ccb_pkg::DIM_W-1:0]   out_col_end,
  output logic [ccb_pkg::DIM_W-1:0]   out_row_first,
  output logic [ccb_pkg::DIM_W-1:0]   out_row_end
);
  import ccb_pkg::*;

  function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    if (v < DIM_W'(2)) return DIM_W'(2);
    if (v > maxv) return maxv;
    return v;
  endfunction

  // configuration
  logic [DIM_W-1:0] width_r, height_r;
  logic [CF_W-1:0]  cfrac_r;
  logic [MF_W-1:0]  mfrac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      cfrac_r  <= RST_CFRAC;
      mfrac_r  <= RST_MFRAC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        CFG_CONTRAST_FR:  cfrac_r  <= cfg_data;
        CFG_MAX_CROP_FR:  mfrac_r  <= cfg_data[MF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff, n_ax;
  assign w_eff = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign h_eff = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));
  assign n_ax  = cmd.axis ? h_eff : w_eff;

  // stream state
  logic [PIX_W-1:0] pix_r, prev_pix_r;
  logic [SUM_W-1:0] row_acc_r;
  logic [TOT_W-1:0] row_tot_r, col_tot_r;
  logic [X_W-1:0]   x_r;
  logic [Y_W-1:0]   y_r;
  logic [X_W-1:0]   clr_cnt_r;

  // scan state
  logic [GOAL_W-1:0] goal_r;
  logic [DIM_W-1:0]  cm_r, l_r;
  logic [TOT_W-1:0]  cum_r;
  logic              found_r, vld_r, back_r;
  logic [SCAN_W-1:0] fidx_r, sc_addr_r, idx_d_r;
  logic [DIM_W-1:0]  sc_cnt_r;
  logic [DIM_W-1:0]  cf_r, ce_r, rf_r, re_r;

  // line stores
  logic [SUM_W-1:0] col_mem [MAX_WIDTH];
  logic [SUM_W-1:0] row_mem [MAX_HEIGHT];
  logic [PIX_W-1:0] prl_mem [MAX_WIDTH];
  logic [SUM_W-1:0] col_rd_r, row_rd_r;
  logic [PIX_W-1:0] prl_rd_r;

  logic             col_we, row_we, prl_we;
  logic [X_W-1:0]   col_wa, col_ra;
  logic [SUM_W-1:0] col_wd;

  // pixel update
  logic [PIX_W-1:0] dcol, drow;
  logic [SUM_W-1:0] row_acc_nxt;
  logic             row_end, last_row;

  assign dcol        = absdiff(pix_r, prl_rd_r);
  assign drow        = absdiff(pix_r, prev_pix_r);
  assign row_acc_nxt = (x_r != '0) ? row_acc_r + SUM_W'(drow) : row_acc_r;
  assign row_end     = (DIM_W'(x_r) + DIM_W'(1)) >= w_eff;
  assign last_row    = (DIM_W'(y_r) + DIM_W'(1)) >= h_eff;

  assign col_we = cmd.clr | (cmd.pix & (y_r != '0));
  assign col_wa = cmd.clr ? clr_cnt_r : x_r;
  assign col_wd = cmd.clr ? '0 : col_rd_r + SUM_W'(dcol);
  assign col_ra = cmd.scan ? sc_addr_r[X_W-1:0] : x_r;
  assign prl_we = cmd.pix;
  assign row_we = cmd.pix & row_end;

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_rd_r <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (prl_we) prl_mem[x_r] <= pix_r;
    prl_rd_r <= prl_mem[x_r];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[y_r] <= row_acc_nxt;
    row_rd_r <= row_mem[sc_addr_r[Y_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) pix_r <= in_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pix_r <= '0;
      row_acc_r  <= '0;
      row_tot_r  <= '0;
      col_tot_r  <= '0;
      x_r        <= '0;
      y_r        <= '0;
      clr_cnt_r  <= '0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + X_W'(1);
      if (cmd.pix) begin
        prev_pix_r <= pix_r;
        if (y_r != '0) col_tot_r <= col_tot_r + TOT_W'(dcol);
        if (row_end) begin
          row_tot_r <= row_tot_r + TOT_W'(row_acc_nxt);
          row_acc_r <= '0;
          x_r       <= '0;
          if (!last_row) y_r <= y_r + Y_W'(1);
        end else begin
          row_acc_r <= row_acc_nxt;
          x_r       <= x_r + X_W'(1);
        end
      end
      if (cmd.fin) begin
        prev_pix_r <= '0;
        row_acc_r  <= '0;
        row_tot_r  <= '0;
        col_tot_r  <= '0;
        x_r        <= '0;
        y_r        <= '0;
      end
    end
  end

  // bound scan
  logic [TOT_W-1:0]  total_ax, cum_nxt;
  logic [GOAL_W-1:0] goal_nxt;
  logic [CM_W-1:0]   cm_prod;
  logic [SUM_W-1:0]  sc_data;
  logic              issue, hit;
  logic [DIM_W-1:0]  r_val, low_val, first_val, end_val;

  assign total_ax = cmd.axis ? row_tot_r : col_tot_r;
  assign goal_nxt = GOAL_W'(total_ax) * GOAL_W'(cfrac_r);
  assign cm_prod  = CM_W'(n_ax) * CM_W'(mfrac_r) + HALF_Q16;
  assign sc_data  = cmd.axis ? row_rd_r : col_rd_r;
  assign cum_nxt  = cum_r + TOT_W'(sc_data);
  assign hit      = {1'b0, cum_nxt, {FRAC_SH{1'b0}}} >= goal_r;
  assign issue    = cmd.scan & (sc_cnt_r != '0) & ~found_r;

  assign r_val     = found_r ? DIM_W'(fidx_r) : '0;
  assign low_val   = n_ax - DIM_W'(1) - cm_r;
  assign first_val = (l_r < cm_r) ? l_r : cm_r;
  assign end_val   = ((cm_r >= n_ax) ? r_val : ((r_val > low_val) ? r_val : low_val))
                     + DIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      vld_r    <= 1'b0;
      back_r   <= 1'b0;
      sc_cnt_r <= '0;
    end else if (cmd.goal) begin
      goal_r    <= goal_nxt;
      cm_r      <= cm_prod[FRAC_SH +: DIM_W];
      cum_r     <= '0;
      found_r   <= 1'b0;
      vld_r     <= 1'b0;
      back_r    <= 1'b0;
      sc_addr_r <= '0;
      sc_cnt_r  <= n_ax;
    end else if (cmd.back_init) begin
      l_r       <= found_r ? DIM_W'(fidx_r) : n_ax;
      cum_r     <= '0;
      found_r   <= 1'b0;
      vld_r     <= 1'b0;
      back_r    <= 1'b1;
      sc_addr_r <= SCAN_W'(n_ax - DIM_W'(1));
      sc_cnt_r  <= n_ax - DIM_W'(1);
    end else begin
      vld_r   <= issue;
      idx_d_r <= sc_addr_r;
      if (issue) begin
        // front scan counts up, back scan counts down
        sc_addr_r <= back_r ? sc_addr_r - SCAN_W'(1) : sc_addr_r + SCAN_W'(1);
        sc_cnt_r  <= sc_cnt_r - DIM_W'(1);
      end
      if (vld_r && !found_r) begin
        cum_r <= cum_nxt;
        if (hit) begin
          found_r <= 1'b1;
          fidx_r  <= idx_d_r;
        end
      end
    end
  end

  assign status.scan_done = found_r | ((sc_cnt_r == '0) & ~vld_r);
  assign status.img_end   = row_end & last_row;
  assign status.clr_last  = (clr_cnt_r == X_W'(MAX_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.back_fin) begin
      if (cmd.axis) begin
        rf_r <= first_val;
        re_r <= end_val;
      end else begin
        cf_r <= first_val;
        ce_r <= end_val;
      end
    end
  end

  assign out_col_first = cf_r;
  assign out_col_end   = ce_r;
  assign out_row_first = rf_r;
  assign out_row_end   = re_r;

endmodule

[rtl/core/contrast_crop_bounds_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_crop_bounds_core
// Contrast-based crop bounds of a raster-order grayscale image.
// ----------------------------------------------------------------------------
// Pixels: each taken pixel gets an update state (registered read-modify-write
//   of the column and previous-line stores) before the next one is taken.
// Result: after the last pixel, the column axis and then the row axis are
//   each scanned front and back over their line-sum store, then out_valid.
// After reset and after each result the column store is swept to zero with
//   busy high; results cannot be held off.
module contrast_crop_bounds_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ccb_pkg::PIX_W-1:0]   in_pixel,
  output logic                        out_valid,
  output logic [ccb_pkg::DIM_W-1:0]   out_col_first,
  output logic [ccb_pkg::DIM_W-1:0]   out_col_end,
  output logic [ccb_pkg::DIM_W-1:0]   out_row_first,
  output logic [ccb_pkg::DIM_W-1:0]   out_row_end,
  input  logic                        cfg_we,
  input  logic [ccb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ccb_pkg::CF_W-1:0]    cfg_data
);
  import ccb_pkg::*;

  cmd_t    cmd;
  status_t status;

  ccb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ccb_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_pixel      (in_pixel),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_col_first (out_col_first),
    .out_col_end   (out_col_end),
    .out_row_first (out_row_first),
    .out_row_end   (out_row_end)
  );

endmodule
